>>> rtl/lms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lms_pkg
// Shared constants and types for the LMS adaptive FIR unit.
// ----------------------------------------------------------------------------
package lms_pkg;
	localparam int Taps = 16;
	localparam int TapW = $clog2(Taps);
	localparam int SampleW = 16;
	localparam int WeightW = 32;
	localparam int StepW = 16;
	localparam int AccW = 64;
	localparam logic [StepW-1:0] StepReset = 16'd1678;

	// Control handed from the sequencer to the datapath.
	typedef struct packed {
		logic            clr;   // clear the accumulator
		logic            mac;   // accumulate product of read data
		logic            upd;   // marks the weight update pass; unused by the datapath
		logic            fin;   // form output and error from the sum
	} lms_ctrl_t;
endpackage
`default_nettype wire

>>> rtl/lms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lms_ram
// Generic simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lms_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	input  wire logic [Width-1:0]         wdata,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem_q [Depth];

	// One write and one registered read per cycle. A read of the entry being
	// written in the same cycle returns its old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/lms_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lms_dp
// Multiply-accumulate datapath: filter sum, output, error and weight
// update arithmetic.
// ----------------------------------------------------------------------------
module lms_dp (
	input  wire logic                                 clk,
	input  wire lms_pkg::lms_ctrl_t                   ctrl,
	input  wire logic signed [lms_pkg::SampleW-1:0]   tap_rd,
	input  wire logic signed [lms_pkg::WeightW-1:0]   wgt_rd,
	input  wire logic signed [lms_pkg::SampleW-1:0]   desired,
	input  wire logic        [lms_pkg::StepW-1:0]     step,
	output logic signed [lms_pkg::SampleW-1:0]        y_q,
	output logic signed [lms_pkg::SampleW-1:0]        e_q,
	output logic signed [lms_pkg::WeightW-1:0]        new_wgt
);
	localparam int PW = lms_pkg::WeightW + lms_pkg::SampleW;
	logic signed [lms_pkg::AccW-1:0] acc_q;
	logic signed [PW-1:0] prod;
	logic signed [lms_pkg::AccW-1:0] rnd;
	logic signed [lms_pkg::AccW-1:0] ysh;
	logic signed [lms_pkg::SampleW-1:0] ysat;
	logic signed [lms_pkg::SampleW+1:0] ediff;
	logic signed [lms_pkg::StepW+lms_pkg::SampleW:0] se_q;
	logic signed [lms_pkg::StepW+2*lms_pkg::SampleW:0] t;
	logic signed [lms_pkg::StepW+2*lms_pkg::SampleW:0] dw;
	logic signed [lms_pkg::WeightW+1:0] nw;

	// Filter product and rounded, saturated output.
	assign prod = wgt_rd * tap_rd;
	assign rnd  = acc_q + (64'sd1 <<< 23);
	assign ysh  = rnd >>> 24;
	always_comb begin
		if (ysh > 64'sd32767) begin
			ysat = 16'sh7fff;
		end else if (ysh < -64'sd32768) begin
			ysat = -16'sh8000;
		end else begin
			ysat = ysh[lms_pkg::SampleW-1:0];
		end
	end
	assign ediff = {{2{desired[15]}}, desired} - {{2{ysat[15]}}, ysat};

	// Weight update from step times error, formed once per item.
	assign t  = se_q * tap_rd;
	assign dw = (t + 49'sd524288) >>> 20;
	assign nw = {{2{wgt_rd[31]}}, wgt_rd} + dw[lms_pkg::WeightW+1:0];
	always_comb begin
		if (nw > 34'sh07fffffff) begin
			new_wgt = 32'sh7fffffff;
		end else if (nw < -34'sh080000000) begin
			new_wgt = 32'sh80000000;
		end else begin
			new_wgt = nw[lms_pkg::WeightW-1:0];
		end
	end

	// Accumulator and result registers.
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.mac) begin
			acc_q <= acc_q + {{(lms_pkg::AccW-PW){prod[PW-1]}}, prod};
		end
		if (ctrl.fin) begin
			y_q <= ysat;
			if (ediff > 18'sd32767) begin
				e_q <= 16'sh7fff;
			end else if (ediff < -18'sd32768) begin
				e_q <= -16'sh8000;
			end else begin
				e_q <= ediff[15:0];
			end
		end
		se_q <= $signed({1'b0, step}) * e_q;
	end
	logic unused_upd;
	assign unused_upd = ctrl.upd;
endmodule
`default_nettype wire

>>> rtl/lms_adaptive_fir_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lms_adaptive_fir_unit
// 16-tap LMS adaptive FIR filter on two synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
// An input word (sample_in, desired_in, adapt) is taken when in_valid is high
// and in_stall is low. One result word (filter_out, error_out) follows, taken
// when out_valid is high and out_stall is low.
// One pass shifts the delay line and accumulates weight times tap; with
// adapt set a second pass rewrites the weights. No new word is taken
// until these passes are done and the result is in the output register.
// The result is held in an output register; the next word is accepted while
// an earlier result waits. If a result is still waiting when a new one is
// done, the unit waits for the receiver.
// step_size is written via cfg_valid/cfg_ready while the unit is idle.
// Reset: after arst_n both memories are cleared entry by entry, during
// which no word is accepted; step_size returns to 1678.
// ----------------------------------------------------------------------------
module lms_adaptive_fir_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] sample_in,
	input  wire logic [15:0] desired_in,
	input  wire logic        adapt,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      filter_out,
	output logic [15:0]      error_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] step_size
);
	localparam int TW = lms_pkg::TapW;

	typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_FILT, ST_FIN, ST_ERR, ST_UPD, ST_OUT}
		state_t;
	state_t state_q;
	logic [TW:0] idx_q;
	logic [15:0] step_q;
	logic [15:0] samp_q, des_q;
	logic adapt_q;
	logic out_valid_q;
	logic [15:0] fo_q, eo_q;

	logic tap_we, wgt_we;
	logic [TW-1:0] tap_addr, wgt_waddr, wgt_raddr;
	logic [15:0] tap_wd, tap_rd;
	logic [31:0] wgt_wd, wgt_rd, new_wgt;
	logic [15:0] y_w, e_w;
	lms_pkg::lms_ctrl_t ctrl;
	logic rd_ok_q;
	logic [TW-1:0] rd_idx_q;
	logic [15:0] tapw_q;
	logic [15:0] dp_tap;

	// Memory ports; the update pass writes each weight in the cycle after its read.
	lms_ram #(.Width(16), .Depth(lms_pkg::Taps)) u_tap (
		.clk(clk), .we(tap_we), .waddr(tap_addr), .raddr(tap_addr), .wdata(tap_wd),
		.rdata(tap_rd));
	lms_ram #(.Width(32), .Depth(lms_pkg::Taps)) u_wgt (
		.clk(clk), .we(wgt_we), .waddr(wgt_waddr), .raddr(wgt_raddr), .wdata(wgt_wd),
		.rdata(wgt_rd));

	// The filter pass multiplies by the shifted tap held in tapw_q; the
	// update pass uses the tap read back from memory.
	assign dp_tap = (state_q == ST_UPD) ? tap_rd : tapw_q;

	lms_dp u_dp (
		.clk(clk), .ctrl(ctrl), .tap_rd(dp_tap), .wgt_rd(wgt_rd),
		.desired(des_q), .step(step_q), .y_q(y_w), .e_q(e_w), .new_wgt(new_wgt));

	// Filter pass: cycle k reads tap k and writes the value of tap k-1 read
	// in the cycle before.
	always_comb begin
		tap_we = 1'b0;
		wgt_we = 1'b0;
		tap_addr = idx_q[TW-1:0];
		wgt_waddr = idx_q[TW-1:0];
		wgt_raddr = idx_q[TW-1:0];
		tap_wd = '0;
		wgt_wd = '0;
		ctrl = '0;
		unique case (state_q)
			ST_CLR: begin
				tap_we = 1'b1;
				wgt_we = 1'b1;
			end
			ST_FILT: begin
				// Read tap idx and write the newer value into it, then
				// accumulate using the value just written.
				tap_we = 1'b1;
				tap_wd = (idx_q == '0) ? samp_q : tap_rd;
				ctrl.mac = rd_ok_q;
			end
			ST_FIN: begin
				ctrl.mac = rd_ok_q;
			end
			ST_ERR: begin
				ctrl.fin = 1'b1;
			end
			ST_UPD: begin
				wgt_we = rd_ok_q;
				wgt_waddr = rd_idx_q;
				wgt_wd = new_wgt;
				ctrl.upd = 1'b1;
			end
			default: begin
			end
		endcase
		if (state_q == ST_IDLE && !in_stall && in_valid) begin
			ctrl.clr = 1'b1;
		end
	end

	// In ST_FILT the same address is read and written in one cycle, so the
	// RAM returns the old value, which is shifted into the next tap. The
	// accumulator uses the value written, held in tapw_q.

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
			step_q <= lms_pkg::StepReset;
		end else begin
			if (cfg_valid && cfg_ready) begin
				step_q <= step_size;
			end
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					rd_ok_q <= 1'b0;
					if (idx_q[TW-1:0] == TW'(lms_pkg::Taps - 1)) begin
						idx_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					rd_ok_q <= 1'b0;
					if (in_valid) begin
						state_q <= ST_FILT;
						idx_q <= '0;
					end
				end
				ST_FILT: begin
					rd_ok_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if (idx_q[TW-1:0] == TW'(lms_pkg::Taps - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					rd_ok_q <= 1'b0;
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					rd_ok_q <= 1'b0;
					idx_q <= '0;
					state_q <= adapt_q ? ST_UPD : ST_OUT;
				end
				ST_UPD: begin
					rd_ok_q <= !idx_q[TW];
					if (!idx_q[TW]) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_ok_q && rd_idx_q == TW'(lms_pkg::Taps - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					rd_ok_q <= 1'b0;
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					rd_ok_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q[TW-1:0];
		if (state_q == ST_IDLE && in_valid) begin
			samp_q <= sample_in;
			des_q <= desired_in;
			adapt_q <= adapt;
		end
		if (state_q == ST_FILT) begin
			tapw_q <= tap_wd;
		end
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			fo_q <= y_w;
			eo_q <= e_w;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign filter_out = fo_q;
	assign error_out = eo_q;

	// Checks.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(filter_out)))
		else $error("result lost");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> (state_q == ST_IDLE)) else $error("cfg while busy");
endmodule
`default_nettype wire

>>> tb/lms_adaptive_fir_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_adaptive_fir_unit_tb
// Self-checking testbench for the 16-tap LMS adaptive FIR unit. A directed
// table followed by random words is driven with random gaps and output stalls.
// A software filter predicts every output and error word, which are compared
// in order against the unit's results. The step size is changed between
// phases while the unit is idle.
// ----------------------------------------------------------------------------
module lms_adaptive_fir_unit_tb;

	localparam string PassMsg = "lms_adaptive_fir_unit verification clean";
	localparam string FailMsg = "lms_adaptive_fir_unit verification failed";
	localparam int    NumRandom = 1900;
	localparam int    DrainCycles = 200;

	typedef struct packed {
		logic [15:0] sample;
		logic [15:0] desired;
		logic        adapt;
	} in_word_t;

	typedef struct packed {
		logic        check_lit;  // compare against the literal fields below
		logic [15:0] filt;
		logic [15:0] err;
	} out_word_t;

	typedef struct {
		in_word_t  stim;
		out_word_t lit;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] sample_in;
	logic [15:0] desired_in;
	logic        adapt;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] filter_out;
	logic [15:0] error_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] step_size;

	// Predictor state.
	logic signed [lms_pkg::SampleW-1:0] mdl_taps [lms_pkg::Taps];
	logic signed [lms_pkg::WeightW-1:0] mdl_wts  [lms_pkg::Taps];
	logic        [lms_pkg::StepW-1:0]   mdl_step;

	out_word_t expected_q [$];
	int        error_count;
	bit        hold_mode;     // receiver long hold-off request
	bit        no_stall;      // receiver never stalls in this phase

	lms_adaptive_fir_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.desired_in (desired_in),
		.adapt      (adapt),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.filter_out (filter_out),
		.error_out  (error_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.step_size  (step_size)
	);

	// 2 ns clock.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Run limit.
	initial begin
		#20ms;
		$display(FailMsg);
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("MISMATCH %s: got %0d want %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		error_count++;
	endtask

	function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
			input int sh);
		return v >>> sh;
	endfunction

	function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Filter one word, adapt the weights if asked, and return the expected result.
	function automatic out_word_t lms_filter_step(input in_word_t w);
		logic signed [63:0] acc;
		logic signed [63:0] y;
		logic signed [63:0] e;
		logic signed [63:0] t;
		out_word_t r;
		acc = 0;
		for (int i = lms_pkg::Taps - 1; i > 0; i--) mdl_taps[i] = mdl_taps[i-1];
		mdl_taps[0] = w.sample;
		for (int i = 0; i < lms_pkg::Taps; i++)
			acc += 64'(mdl_wts[i]) * 64'(mdl_taps[i]);
		y = clamp(floor_shr(acc + (64'sd1 <<< 23), 24), -32768, 32767);
		e = clamp(64'($signed(w.desired)) - y, -32768, 32767);
		if (w.adapt) begin
			for (int i = 0; i < lms_pkg::Taps; i++) begin
				t = 64'($signed({1'b0, mdl_step})) * e * 64'(mdl_taps[i]);
				t = floor_shr(t + (64'sd1 <<< 19), 20);
				mdl_wts[i] = 32'(clamp(64'(mdl_wts[i]) + t,
					-64'sd2147483648, 64'sd2147483647));
			end
		end
		r.check_lit = 1'b0;
		r.filt = y[15:0];
		r.err = e[15:0];
		return r;
	endfunction

	// Send one word with a random lead-in gap, queueing its expectation.
	// The word stays offered until the next word or an idle wait replaces it.
	task automatic send_word(input in_word_t w, input out_word_t lit, input int gap);
		out_word_t p;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= w.sample;
		desired_in <= w.desired;
		adapt <= w.adapt;
		p = lms_filter_step(w);
		if (lit.check_lit) begin
			if (lit.filt !== p.filt) report_mismatch("table filter", p.filt, lit.filt);
			if (lit.err !== p.err) report_mismatch("table error", p.err, lit.err);
		end
		expected_q.push_back(p);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_step(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		step_size <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mdl_step = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rnd_sample();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 8191)) - 16'd4096;
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, plus a long hold-off when requested.
	initial begin
		int wait_n;
		out_word_t want;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_mode) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_mode = 1'b0;
			end
			wait_n = no_stall ? 0 : $urandom_range(0, 18);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", filter_out, 16'h0000);
			end else begin
				want = expected_q.pop_front();
				if (filter_out !== want.filt)
					report_mismatch("filter_out", filter_out, want.filt);
				if (error_out !== want.err)
					report_mismatch("error_out", error_out, want.err);
			end
		end
	end

	// Stimulus.
	initial begin
		dir_row_t  dir_tab [$];
		in_word_t  w;
		out_word_t none;
		logic [15:0] steps [6];
		none = '0;
		in_valid = 1'b0;
		sample_in = '0;
		desired_in = '0;
		adapt = 1'b0;
		cfg_valid = 1'b0;
		step_size = '0;
		error_count = 0;
		hold_mode = 1'b0;
		no_stall = 1'b0;
		mdl_step = lms_pkg::StepReset;
		for (int i = 0; i < lms_pkg::Taps; i++) begin
			mdl_taps[i] = '0;
			mdl_wts[i] = '0;
		end
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: zero weights give a zero output after reset, so
		// the error equals the desired sample until adaptation kicks in.
		dir_tab.push_back('{'{16'h7FFF, 16'h8000, 1'b0}, '{1'b1, 16'h0000, 16'h8000}});
		dir_tab.push_back('{'{16'h8000, 16'h7FFF, 1'b0}, '{1'b1, 16'h0000, 16'h7FFF}});
		dir_tab.push_back('{'{16'h0000, 16'h0000, 1'b1}, '{1'b1, 16'h0000, 16'h0000}});
		dir_tab.push_back('{'{16'h7FFF, 16'h7FFF, 1'b1}, none});
		for (int i = 0; i < 12; i++)
			dir_tab.push_back('{'{16'h7FFF, 16'h7FFF, 1'b1}, none});
		dir_tab.push_back('{'{16'h8000, 16'h8000, 1'b1}, none});
		dir_tab.push_back('{'{16'h8000, 16'h7FFF, 1'b1}, none});
		dir_tab.push_back('{'{16'h1000, 16'h8000, 1'b0}, none});
		dir_tab.push_back('{'{16'h5555, 16'hAAAA, 1'b1}, none});
		dir_tab.push_back('{'{16'hAAAA, 16'h5555, 1'b0}, none});
		foreach (dir_tab[k])
			send_word(dir_tab[k].stim, dir_tab[k].lit, $urandom_range(0, 18));
		wait_idle();

		// Step sizes: extremes, zero (frozen adaptation) and typical values.
		steps = '{16'hFFFF, 16'd0, 16'd1, 16'd1678, 16'd8000, 16'($urandom)};
		for (int ph = 0; ph < 6; ph++) begin
			write_step(steps[ph]);
			for (int n = 0; n < NumRandom / 6; n++) begin
				w.sample = rnd_sample();
				w.desired = rnd_sample();
				w.adapt = ($urandom_range(0, 3) != 0);
				// Back-to-back stretches without gaps in some words.
				send_word(w, none, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
				if (ph == 1 && n == 20) hold_mode = 1'b1;
				if (ph == 2 && n == 100) wait_idle();
				if (ph == 3) no_stall = (n < 100);
			end
			no_stall = 1'b0;
			wait_idle();
		end

		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display(PassMsg);
		end else begin
			$display(FailMsg);
		end
		$finish;
	end
endmodule

>>> sim.f
rtl/lms_pkg.sv
rtl/lms_ram.sv
rtl/lms_dp.sv
rtl/lms_adaptive_fir_unit.sv
tb/lms_adaptive_fir_unit_tb.sv
